// ----- design/lzwd_pkg.sv -----
package lzwd_pkg;

	// History window and address width
	localparam int HIST_DEPTH = 2048;
	localparam int HIST_AW = $clog2(HIST_DEPTH);

	// Width of byte counts, output limit and decoded length
	localparam int LEN_W = 25;

	// Output tdata: out_word, valid_bytes, decoded_length, padded to whole bytes
	localparam int OUT_TDATA_W = 64;
	localparam int OUT_PAD_W = OUT_TDATA_W - 32 - 3 - LEN_W;

	// Commands from the controller to the datapath
	typedef struct packed {
		logic load;    // take an input byte, decode it, latch the token work
		logic issue;   // issue the first history read
		logic step;    // produce one output byte
		logic status;  // emit a status-only result
	} cmd_t;

	// Status from the datapath to the controller
	typedef struct packed {
		logic cnt_zero;    // the current item produces no byte
		logic final_byte;  // the byte produced now is the last of the item
		logic out_free;    // the output register can take a result this cycle
	} stat_t;

endpackage

// ----- design/lz_window_block_decompressor_core.sv -----
// Each input byte is taken and decoded, then the first history read is issued, then the bytes
// it decodes are produced one byte per cycle while the output register is free; a byte that
// decodes none gives only a status result. A new input byte is taken only after the last
// result of the previous one is produced; a full output register stalls the byte loop.
// Reset (arst_n low, asynchronous) clears parser state, counts, limit and output valid;
// the history RAM is not cleared and needs no sweep.
module lz_window_block_decompressor_core (
	input  logic                                clk,
	input  logic                                arst_n,
	// Compressed input
	input  logic                                s_axis_tvalid,
	output logic                                s_axis_tready,
	input  logic [7:0]                          s_axis_tdata,  // [7:0] data_byte
	input  logic                                s_axis_tlast,  // block_end
	// Decoded output
	output logic                                m_axis_tvalid,
	input  logic                                m_axis_tready,
	// [31:0] out_word, [34:32] valid_bytes, [59:35] decoded_length, [63:60] zero
	output logic [lzwd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
	output logic                                m_axis_tlast,  // run_last
	output logic                                m_axis_tuser,  // block_done
	// Output limit register
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lzwd_pkg::LEN_W-1:0]          cfg_data
);

	lzwd_pkg::cmd_t             cmd;
	lzwd_pkg::stat_t            stat;
	logic [31:0]                out_word;
	logic [2:0]                 out_count;
	logic [lzwd_pkg::LEN_W-1:0] out_length;

	assign cfg_ready = 1'b1;

	lzwd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	lzwd_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_byte    (s_axis_tdata),
		.in_end     (s_axis_tlast),
		.cfg_we     (cfg_valid && cfg_ready),
		.cfg_data   (cfg_data),
		.out_ready  (m_axis_tready),
		.out_valid  (m_axis_tvalid),
		.out_word   (out_word),
		.out_count  (out_count),
		.out_last   (m_axis_tlast),
		.out_done   (m_axis_tuser),
		.out_length (out_length)
	);

	// Pack result fields, lowest field first
	assign m_axis_tdata = {{lzwd_pkg::OUT_PAD_W{1'b0}}, out_length, out_count, out_word};

	// A new result never overwrites one still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step || cmd.status) && m_axis_tvalid |-> m_axis_tready)
		else $error("result register overwritten");

	// At most one datapath command per cycle
	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.load, cmd.issue, cmd.step, cmd.status}))
		else $error("conflicting datapath commands");

	// Block done only comes with the last result of an input byte
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
		else $error("block done without run last");

	// Only the last word of an input byte may be partial
	a_full_words: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tlast |-> out_count == 3'd4)
		else $error("partial word before the last result");

endmodule

// ----- design/lzwd_ram.sv -----
module lzwd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2048,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Write port, and registered read that returns the old value on a collision
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- design/lzwd_ctrl.sv -----
module lzwd_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_ready,
	input  lzwd_pkg::stat_t stat,
	output lzwd_pkg::cmd_t  cmd
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_RUN,
		ST_STATUS
	} state_t;

	state_t state_q;
	logic   ready_q;

	// Decode commands from the current state
	always_comb begin
		cmd.load   = ready_q && in_valid;
		cmd.issue  = (state_q == ST_DECIDE);
		cmd.step   = (state_q == ST_RUN) && stat.out_free;
		cmd.status = (state_q == ST_STATUS) && stat.out_free;
	end

	assign in_ready = ready_q;

	// Sequence one input byte: decode, then produce bytes or a status result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.load) begin
						state_q <= ST_DECIDE;
						ready_q <= 1'b0;
					end
				end
				ST_DECIDE: begin
					if (stat.cnt_zero) begin
						state_q <= ST_STATUS;
					end else begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (cmd.step && stat.final_byte) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_STATUS: begin
					if (cmd.status) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

endmodule

// ----- design/lzwd_dp.sv -----
module lzwd_dp (
	input  logic                       clk,
	input  logic                       arst_n,
	input  lzwd_pkg::cmd_t             cmd,
	output lzwd_pkg::stat_t            stat,
	input  logic [7:0]                 in_byte,
	input  logic                       in_end,
	input  logic                       cfg_we,
	input  logic [lzwd_pkg::LEN_W-1:0] cfg_data,
	input  logic                       out_ready,
	output logic                       out_valid,
	output logic [31:0]                out_word,
	output logic [2:0]                 out_count,
	output logic                       out_last,
	output logic                       out_done,
	output logic [lzwd_pkg::LEN_W-1:0] out_length
);

	typedef enum logic [2:0] {
		PH_FLAG  = 3'd0,
		PH_TOKEN = 3'd1,
		PH_LIT2  = 3'd2,
		PH_LIT3  = 3'd3,
		PH_LIT4  = 3'd4,
		PH_REFHI = 3'd5
	} phase_t;

	typedef enum logic [1:0] {
		SRC_LIT,
		SRC_ZERO,
		SRC_LAST,
		SRC_RAM
	} src_t;

	localparam logic [lzwd_pkg::HIST_AW:0] DEPTH_X =
		(lzwd_pkg::HIST_AW + 1)'(lzwd_pkg::HIST_DEPTH);
	localparam logic [lzwd_pkg::HIST_AW-1:0] PTR_LAST =
		lzwd_pkg::HIST_AW'(lzwd_pkg::HIST_DEPTH - 1);

	// Token parser and block state
	phase_t                       phase_q;
	logic [7:0]                   flags_q;
	logic [2:0]                   pos_q;
	logic [23:0]                  pend_q;
	logic [lzwd_pkg::LEN_W-1:0]   produced_q;
	logic [lzwd_pkg::LEN_W-1:0]   limit_q;
	logic [lzwd_pkg::HIST_AW-1:0] wr_ptr_q;

	// Work of the current item
	logic [7:0]                   cnt_q;
	logic                         end_q;
	src_t                         src_q;
	logic [31:0]                  lit_q;
	logic [lzwd_pkg::HIST_AW-1:0] rd_ptr_q;
	logic [7:0]                   last_byte_q;
	logic [23:0]                  acc_q;
	logic [1:0]                   acc_cnt_q;

	// Output register
	logic                         out_valid_q;
	logic [31:0]                  out_word_q;
	logic [2:0]                   out_count_q;
	logic                         out_last_q;
	logic                         out_done_q;
	logic [lzwd_pkg::LEN_W-1:0]   out_length_q;

	// Decode signals
	phase_t                       phase_n;
	logic [7:0]                   flags_n;
	logic [2:0]                   pos_n;
	logic [23:0]                  pend_n;
	logic                         op_lit;
	logic                         op_copy;
	logic [31:0]                  op_word;
	logic [15:0]                  op_v;
	logic                         room_nz;
	logic [lzwd_pkg::LEN_W-1:0]   room_c;
	logic [5:0]                   len_units;
	logic [7:0]                   len_c;
	logic [7:0]                   cnt_c;
	logic [10:0]                  ofs_raw;
	logic [10:0]                  ofs_c;
	logic [lzwd_pkg::HIST_AW:0]   wr_ext;
	logic [lzwd_pkg::HIST_AW:0]   ofs_ext;
	logic [lzwd_pkg::HIST_AW:0]   rd_sum;
	src_t                         src_c;

	// Step signals
	logic [7:0]                   ram_rdata;
	logic [7:0]                   byte_c;
	logic [31:0]                  word_c;
	logic                         final_c;
	logic                         full_c;
	logic                         emit_c;
	logic [lzwd_pkg::LEN_W-1:0]   prod_inc;
	logic [lzwd_pkg::HIST_AW-1:0] wr_ptr_inc;
	logic [lzwd_pkg::HIST_AW-1:0] rd_ptr_inc;

	// Room left before the output limit
	assign room_nz = (limit_q > produced_q);
	assign room_c  = room_nz ? (limit_q - produced_q) : '0;

	// Parse the input byte and pick the token work it completes
	always_comb begin
		phase_n = phase_q;
		flags_n = flags_q;
		pos_n   = pos_q;
		pend_n  = pend_q;
		op_lit  = 1'b0;
		op_copy = 1'b0;
		op_word = '0;
		op_v    = '0;
		case (phase_q)
			PH_TOKEN: begin
				if (room_nz) begin
					pend_n  = {16'd0, in_byte};
					phase_n = flags_q[3'd7 - pos_q] ? PH_REFHI : PH_LIT2;
				end
			end
			PH_LIT2: begin
				pend_n[15:8] = in_byte;
				phase_n      = PH_LIT3;
			end
			PH_LIT3: begin
				pend_n[23:16] = in_byte;
				phase_n       = PH_LIT4;
			end
			PH_LIT4, PH_REFHI: begin
				if (phase_q == PH_LIT4) begin
					op_lit  = 1'b1;
					op_word = {in_byte, pend_q};
				end else begin
					op_copy = 1'b1;
					op_v    = {in_byte, pend_q[7:0]};
				end
				pend_n = '0;
				if (pos_q == 3'd7) begin
					pos_n   = 3'd0;
					phase_n = PH_FLAG;
				end else begin
					pos_n   = pos_q + 3'd1;
					phase_n = PH_TOKEN;
				end
			end
			default: begin
				if (room_nz) begin
					flags_n = in_byte;
					pos_n   = 3'd0;
					phase_n = PH_TOKEN;
				end
			end
		endcase
		// Block end: pad an open token with zeros, then clear the parser
		if (in_end) begin
			if (phase_n == PH_LIT2 || phase_n == PH_LIT3 || phase_n == PH_LIT4) begin
				op_lit  = 1'b1;
				op_word = {8'd0, pend_n};
			end else if (phase_n == PH_REFHI) begin
				op_copy = 1'b1;
				op_v    = {8'd0, pend_n[7:0]};
			end
			phase_n = PH_FLAG;
			flags_n = '0;
			pos_n   = '0;
			pend_n  = '0;
		end
	end

	// Clamp length to the room left and offset to the bytes produced so far
	always_comb begin
		len_units = {1'b0, op_v[15:11]} + 6'd1;
		len_c     = op_lit ? 8'd4 : {len_units, 2'b00};
		if (op_lit || op_copy) begin
			cnt_c = (room_c < lzwd_pkg::LEN_W'(len_c)) ? room_c[7:0] : len_c;
		end else begin
			cnt_c = 8'd0;
		end
		ofs_raw = op_v[10:0];
		ofs_c   = (lzwd_pkg::LEN_W'(ofs_raw) > produced_q) ? produced_q[10:0] : ofs_raw;
		wr_ext  = {1'b0, wr_ptr_q};
		ofs_ext = (lzwd_pkg::HIST_AW + 1)'(ofs_c);
		rd_sum  = (wr_ext >= ofs_ext) ? (wr_ext - ofs_ext) : (wr_ext + DEPTH_X - ofs_ext);
		if (op_lit) begin
			src_c = SRC_LIT;
		end else if (ofs_c == 11'd0) begin
			src_c = SRC_ZERO;
		end else if (ofs_c == 11'd1) begin
			src_c = SRC_LAST;
		end else begin
			src_c = SRC_RAM;
		end
	end

	// Select the byte produced now; offset one repeats the last byte
	always_comb begin
		case (src_q)
			SRC_LIT:  byte_c = lit_q[7:0];
			SRC_ZERO: byte_c = 8'd0;
			SRC_LAST: byte_c = last_byte_q;
			SRC_RAM:  byte_c = ram_rdata;
			default:  byte_c = 8'd0;
		endcase
	end

	// Pack bytes into the output word, first byte lowest
	assign word_c     = {8'd0, acc_q} | (32'(byte_c) << {acc_cnt_q, 3'b000});
	assign final_c    = (cnt_q == 8'd1);
	assign full_c     = (acc_cnt_q == 2'd3);
	assign emit_c     = (cmd.step && (full_c || final_c)) || cmd.status;
	assign prod_inc   = produced_q + 1'b1;
	assign wr_ptr_inc = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
	assign rd_ptr_inc = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;

	// History window
	lzwd_ram #(
		.WIDTH (8),
		.DEPTH (lzwd_pkg::HIST_DEPTH)
	) u_hist (
		.clk   (clk),
		.we    (cmd.step),
		.waddr (wr_ptr_q),
		.wdata (byte_c),
		.re    (cmd.issue || cmd.step),
		.raddr (rd_ptr_q),
		.rdata (ram_rdata)
	);

	// Control state: parser, counters, limit and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_FLAG;
			flags_q     <= '0;
			pos_q       <= '0;
			pend_q      <= '0;
			produced_q  <= '0;
			limit_q     <= '0;
			wr_ptr_q    <= '0;
			cnt_q       <= '0;
			end_q       <= 1'b0;
			acc_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_data;
			end
			if (cmd.load) begin
				phase_q   <= phase_n;
				flags_q   <= flags_n;
				pos_q     <= pos_n;
				pend_q    <= pend_n;
				cnt_q     <= cnt_c;
				end_q     <= in_end;
				acc_cnt_q <= '0;
			end
			if (cmd.step) begin
				cnt_q     <= cnt_q - 8'd1;
				acc_cnt_q <= (full_c || final_c) ? 2'd0 : acc_cnt_q + 2'd1;
				if (final_c && end_q) begin
					produced_q <= '0;
					wr_ptr_q   <= '0;
				end else begin
					produced_q <= prod_inc;
					wr_ptr_q   <= wr_ptr_inc;
				end
			end
			if (cmd.status && end_q) begin
				produced_q <= '0;
				wr_ptr_q   <= '0;
			end
			if (emit_c) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload: token work, read pointer, byte packing and output fields
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			lit_q    <= op_word;
			src_q    <= src_c;
			rd_ptr_q <= rd_sum[lzwd_pkg::HIST_AW-1:0];
			acc_q    <= '0;
		end
		if (cmd.issue || cmd.step) begin
			rd_ptr_q <= rd_ptr_inc;
		end
		if (cmd.step) begin
			lit_q       <= {8'd0, lit_q[31:8]};
			last_byte_q <= byte_c;
			acc_q       <= (full_c || final_c) ? 24'd0 : word_c[23:0];
			if (full_c || final_c) begin
				out_word_q   <= word_c;
				out_count_q  <= {1'b0, acc_cnt_q} + 3'd1;
				out_last_q   <= final_c;
				out_done_q   <= final_c && end_q;
				out_length_q <= (final_c && end_q) ? prod_inc : '0;
			end
		end
		if (cmd.status) begin
			out_word_q   <= '0;
			out_count_q  <= '0;
			out_last_q   <= 1'b1;
			out_done_q   <= end_q;
			out_length_q <= end_q ? produced_q : '0;
		end
	end

	// Status to the controller
	always_comb begin
		stat.cnt_zero   = (cnt_q == 8'd0);
		stat.final_byte = final_c;
		stat.out_free   = !out_valid_q || out_ready;
	end

	assign out_valid  = out_valid_q;
	assign out_word   = out_word_q;
	assign out_count  = out_count_q;
	assign out_last   = out_last_q;
	assign out_done   = out_done_q;
	assign out_length = out_length_q;

endmodule

// ----- verif/tb_lz_window_block_decompressor_core.sv -----
module tb_lz_window_block_decompressor_core;

	// Parser states of the decoder model
	typedef enum logic [2:0] {
		PS_FLAG,
		PS_TOKEN,
		PS_LIT2,
		PS_LIT3,
		PS_LIT4,
		PS_REF_HI
	} parse_state_t;

	// One decoded result as it leaves on the master side
	typedef struct packed {
		logic [31:0]                word;
		logic [2:0]                 nvalid;
		logic                       run_last;
		logic                       done;
		logic [lzwd_pkg::LEN_W-1:0] dlen;
	} word_result_t;

	// One line of the directed plan: a limit write or a compressed byte
	typedef struct packed {
		logic                       is_cfg;
		logic [lzwd_pkg::LEN_W-1:0] value;
		logic                       block_end;
		logic                       typed;
		word_result_t               res;
	} stim_row_t;

	localparam logic [lzwd_pkg::LEN_W-1:0] LIMIT_MAX = '1;
	localparam int MAX_BURST = 12;
	localparam int DRAIN_CYCLES = 4;
	localparam int TAIL_CYCLES = 8;
	localparam int RANDOM_ITEMS = 320;
	localparam int CALM_ITEMS = 280;
	localparam int DIRECTED_ROWS = 26;

	localparam word_result_t STATUS_ONLY = '{32'h0, 3'd0, 1'b1, 1'b0, 25'd0};
	localparam word_result_t NO_RES = '0;

	// Directed plan: reset limit, extremes, overlap, offset clamp, zero offset,
	// end inside a token, literal clamped at the limit, token dropped at the limit
	localparam stim_row_t PLAN [DIRECTED_ROWS] = '{
		'{1'b0, 25'h0AA, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h055, 1'b1, 1'b1, '{32'h0, 3'd0, 1'b1, 1'b1, 25'd0}},
		'{1'b1, LIMIT_MAX, 1'b0, 1'b0, NO_RES},
		'{1'b0, 25'h07F, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h000, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h0FF, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h080, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h07F, 1'b0, 1'b1, '{32'h7F80FF00, 3'd4, 1'b1, 1'b0, 25'd0}},
		'{1'b0, 25'h001, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h000, 1'b0, 1'b1, '{32'h7F7F7F7F, 3'd4, 1'b1, 1'b0, 25'd0}},
		'{1'b0, 25'h0FF, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h0FF, 1'b0, 1'b0, NO_RES},
		'{1'b0, 25'h000, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h008, 1'b0, 1'b0, NO_RES},
		'{1'b0, 25'h003, 1'b1, 1'b0, NO_RES},
		'{1'b1, 25'd6, 1'b0, 1'b0, NO_RES},
		'{1'b0, 25'h000, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h011, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h022, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h033, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h044, 1'b0, 1'b1, '{32'h44332211, 3'd4, 1'b1, 1'b0, 25'd0}},
		'{1'b0, 25'h055, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h066, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h077, 1'b0, 1'b1, STATUS_ONLY},
		'{1'b0, 25'h088, 1'b0, 1'b1, '{32'h00006655, 3'd2, 1'b1, 1'b0, 25'd0}},
		'{1'b0, 25'h099, 1'b1, 1'b1, '{32'h0, 3'd0, 1'b1, 1'b1, 25'd6}}
	};

	logic                             clk;
	logic                             arst_n;
	logic                             s_axis_tvalid;
	logic                             s_axis_tready;
	logic [7:0]                       s_axis_tdata;   // [7:0] data_byte
	logic                             s_axis_tlast;   // block_end
	logic                             m_axis_tvalid;
	logic                             m_axis_tready;
	// [31:0] out_word, [34:32] valid_bytes, [59:35] decoded_length, [63:60] zero
	logic [lzwd_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
	logic                             m_axis_tlast;   // run_last
	logic                             m_axis_tuser;   // block_done
	logic                             cfg_valid;
	logic                             cfg_ready;
	logic [lzwd_pkg::LEN_W-1:0]       cfg_data;

	// Decoder model state
	logic [7:0]                 win_mem [lzwd_pkg::HIST_DEPTH];
	parse_state_t               pstate;
	logic [7:0]                 flags;
	logic [3:0]                 tok_idx;
	logic [23:0]                partial;
	logic [lzwd_pkg::LEN_W-1:0] produced;
	logic [lzwd_pkg::LEN_W-1:0] out_limit;

	logic [7:0]   step_bytes [$];
	word_result_t step_results [$];
	word_result_t decoded_q [$];

	int errors;
	int taken;
	bit calm;
	int tx_pct;
	int rx_pct;

	lz_window_block_decompressor_core i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data)
	);

	// Free-running clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Bound the run
	initial begin
		#10_000_000;
		$display("FAIL");
		$finish;
	end

	function automatic logic [lzwd_pkg::LEN_W-1:0] room_left();
		return (out_limit > produced) ? out_limit - produced : '0;
	endfunction

	// Write one byte to the window and to this transaction's output
	function automatic void emit_byte(logic [7:0] b);
		win_mem[produced[lzwd_pkg::HIST_AW-1:0]] = b;
		produced = produced + 1'b1;
		step_bytes.push_back(b);
	endfunction

	function automatic void emit_literal(logic [31:0] w);
		int unsigned n;
		n = (room_left() < 4) ? room_left() : 4;
		for (int i = 0; i < n; i++)
			emit_byte(w[8*i +: 8]);
	endfunction

	// Copy from the window one byte at a time so overlaps repeat the pattern
	function automatic void emit_copy(logic [15:0] v);
		logic [lzwd_pkg::LEN_W-1:0] ofs;
		logic [lzwd_pkg::LEN_W-1:0] src;
		int unsigned cnt;
		ofs = v[10:0];
		cnt = (v[15:11] + 1) * 4;
		if (ofs > produced)
			ofs = produced;
		if (cnt > room_left())
			cnt = room_left();
		for (int i = 0; i < cnt; i++) begin
			src = produced - ofs;
			emit_byte((ofs == '0) ? 8'h00 : win_mem[src[lzwd_pkg::HIST_AW-1:0]]);
		end
	endfunction

	function automatic void close_token();
		partial = '0;
		tok_idx = tok_idx + 1'b1;
		if (tok_idx >= 8) begin
			tok_idx = '0;
			pstate = PS_FLAG;
		end else begin
			pstate = PS_TOKEN;
		end
	endfunction

	function automatic void clear_block();
		pstate = PS_FLAG;
		flags = '0;
		tok_idx = '0;
		partial = '0;
		produced = '0;
	endfunction

	// Advance the model by one compressed byte; fill step_results, return 0 if ignored
	function automatic bit decode_byte(logic [7:0] b, logic e);
		bit took;
		logic [lzwd_pkg::LEN_W-1:0] total;
		int unsigned nres;
		int unsigned idx;
		word_result_t r;
		took = 1'b1;
		total = '0;
		step_bytes.delete();
		step_results.delete();
		case (pstate)
			PS_TOKEN: begin
				if (room_left() == '0) begin
					took = 1'b0;
				end else begin
					partial = {16'h0, b};
					pstate = flags[7 - tok_idx] ? PS_REF_HI : PS_LIT2;
				end
			end
			PS_LIT2: begin
				partial[15:8] = b;
				pstate = PS_LIT3;
			end
			PS_LIT3: begin
				partial[23:16] = b;
				pstate = PS_LIT4;
			end
			PS_LIT4: begin
				emit_literal({b, partial});
				close_token();
			end
			PS_REF_HI: begin
				emit_copy({b, partial[7:0]});
				close_token();
			end
			default: begin
				if (room_left() == '0) begin
					took = 1'b0;
				end else begin
					flags = b;
					tok_idx = '0;
					pstate = PS_TOKEN;
				end
			end
		endcase
		// Pad a token cut off by the block end with zeros
		if (e) begin
			if (pstate == PS_LIT2 || pstate == PS_LIT3 || pstate == PS_LIT4)
				emit_literal({8'h00, partial});
			else if (pstate == PS_REF_HI)
				emit_copy({8'h00, partial[7:0]});
			total = produced;
			clear_block();
		end
		// Pack four bytes per word; no byte means one status result
		nres = (step_bytes.size() == 0) ? 1 : (step_bytes.size() + 3) / 4;
		for (int k = 0; k < nres; k++) begin
			r = '0;
			for (int i = 0; i < 4; i++) begin
				idx = k * 4 + i;
				if (idx < step_bytes.size()) begin
					r.word[8*i +: 8] = step_bytes[idx];
					r.nvalid = r.nvalid + 1'b1;
				end
			end
			r.run_last = (k == nres - 1);
			r.done = r.run_last && e;
			r.dlen = r.done ? total : '0;
			step_results.push_back(r);
		end
		return took;
	endfunction

	task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
		errors++;
	endtask

	// Hold valid low for a random burst
	task automatic idle_tx();
		if (!calm && $urandom_range(0, 99) < tx_pct) begin
			@(negedge clk) s_axis_tvalid = 1'b0;
			repeat ($urandom_range(0, MAX_BURST - 1)) @(negedge clk);
		end
	endtask

	// Present one byte, wait for its transaction, queue what it decodes to
	task automatic send_byte(logic [7:0] b, logic e, logic typed, word_result_t typed_res);
		idle_tx();
		@(negedge clk);
		s_axis_tvalid = 1'b1;
		s_axis_tdata = b;
		s_axis_tlast = e;
		do @(posedge clk); while (!s_axis_tready);
		void'(decode_byte(b, e));
		taken++;
		if (taken >= CALM_ITEMS)
			calm = 1'b1;
		if (typed)
			decoded_q.push_back(typed_res);
		else
			foreach (step_results[i])
				decoded_q.push_back(step_results[i]);
	endtask

	// Drain all results, let the block settle, then write the limit
	task automatic write_limit(logic [lzwd_pkg::LEN_W-1:0] v);
		@(negedge clk) s_axis_tvalid = 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		@(negedge clk);
		cfg_valid = 1'b1;
		cfg_data = v;
		do @(posedge clk); while (!cfg_ready);
		out_limit = v;
		@(negedge clk) cfg_valid = 1'b0;
	endtask

	// Build a block of flag groups with random content, or plain noise, and send it
	task automatic send_block(bit wellformed, bit close);
		logic [7:0] blk [$];
		logic [7:0] fl;
		logic [10:0] ofs;
		logic [4:0] lenf;
		int n;
		if (wellformed) begin
			repeat ($urandom_range(1, 2)) begin
				fl = 8'($urandom);
				blk.push_back(fl);
				for (int t = 0; t < 8; t++) begin
					if (fl[7 - t]) begin
						ofs = $urandom_range(0, 1) ? 11'($urandom_range(0, 16)) : 11'($urandom);
						lenf = ($urandom_range(0, 7) == 0) ? 5'($urandom) : 5'($urandom_range(0, 3));
						blk.push_back(ofs[7:0]);
						blk.push_back({lenf, ofs[10:8]});
					end else begin
						repeat (4) blk.push_back(8'($urandom));
					end
				end
			end
		end else begin
			repeat ($urandom_range(1, 20)) blk.push_back(8'($urandom));
		end
		n = $urandom_range(0, 1) ? blk.size() : $urandom_range(1, blk.size());
		for (int i = 0; i < n; i++)
			send_byte(blk[i], close && (i == n - 1), 1'b0, NO_RES);
	endtask

	// Result side backpressure
	initial begin
		m_axis_tready = 1'b1;
		forever begin
			@(negedge clk);
			if (!calm && $urandom_range(0, 99) < rx_pct) begin
				m_axis_tready = 1'b0;
				repeat ($urandom_range(1, MAX_BURST)) @(negedge clk);
			end
			m_axis_tready = 1'b1;
		end
	end

	// Compare each result transaction with the oldest expectation
	always @(posedge clk) begin : check_results
		word_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (decoded_q.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, 64'd0);
			end else begin
				want = decoded_q.pop_front();
				if (m_axis_tdata[31:0] !== want.word)
					report_mismatch("out_word", 64'(m_axis_tdata[31:0]), 64'(want.word));
				if (m_axis_tdata[34:32] !== want.nvalid)
					report_mismatch("valid_bytes", 64'(m_axis_tdata[34:32]), 64'(want.nvalid));
				if (m_axis_tdata[59:35] !== want.dlen)
					report_mismatch("decoded_length", 64'(m_axis_tdata[59:35]),
						64'(want.dlen));
				if (m_axis_tdata[63:60] !== 4'd0)
					report_mismatch("tdata padding", 64'(m_axis_tdata[63:60]), 64'd0);
				if (m_axis_tlast !== want.run_last)
					report_mismatch("run_last", 64'(m_axis_tlast), 64'(want.run_last));
				if (m_axis_tuser !== want.done)
					report_mismatch("block_done", 64'(m_axis_tuser), 64'(want.done));
			end
		end
	end

	// Reset, directed plan, random phases, drain
	initial begin
		logic [lzwd_pkg::LEN_W-1:0] lim;
		int nblk;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		errors = 0;
		taken = 0;
		calm = 1'b0;
		tx_pct = 20;
		rx_pct = 20;
		clear_block();
		out_limit = '0;
		repeat (7) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		foreach (PLAN[i]) begin
			if (PLAN[i].is_cfg)
				write_limit(PLAN[i].value);
			else
				send_byte(PLAN[i].value[7:0], PLAN[i].block_end, PLAN[i].typed, PLAN[i].res);
		end

		// Each phase sets a new limit, possibly in the middle of an open block
		taken = 0;
		while (taken < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0:       lim = '0;
				1, 2:    lim = lzwd_pkg::LEN_W'($urandom_range(1, 64));
				3, 4, 5: lim = lzwd_pkg::LEN_W'($urandom_range(65, 4000));
				6:       lim = lzwd_pkg::LEN_W'($urandom);
				default: lim = LIMIT_MAX;
			endcase
			write_limit(lim);
			case ($urandom_range(0, 2))
				0:       tx_pct = 0;
				1:       tx_pct = 15;
				default: tx_pct = 40;
			endcase
			case ($urandom_range(0, 2))
				0:       rx_pct = 0;
				1:       rx_pct = 10;
				default: rx_pct = 35;
			endcase
			nblk = $urandom_range(1, 3);
			for (int bi = 0; bi < nblk; bi++)
				send_block($urandom_range(0, 4) != 0, (bi < nblk - 1) || ($urandom_range(0, 3) != 0));
		end

		@(negedge clk) s_axis_tvalid = 1'b0;
		while (decoded_q.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && decoded_q.size() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
